>>> rtl/core/bcpf_pkg.sv
// ----------------------------------------------------------------------------
// bcpf_pkg
// Shared sizes, command and status codes and sequencer states for the
// point-in-box lookup core.
// ----------------------------------------------------------------------------
package bcpf_pkg;

    // table geometry
    localparam int NUM_LEVELS  = 8;
    localparam int MAX_BOXES   = 256;
    localparam int COORD_WIDTH = 16;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int BOX_W  = $clog2(MAX_BOXES);
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W = LVL_W + BOX_W;
    localparam int ENTRY_W = 6 * COORD_WIDTH;

    // fixed field widths of the ports
    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 3;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int DIMS_W   = 2;

    // number of active axes that drops z from the scan
    localparam logic [DIMS_W-1:0] DIMS_TWO = DIMS_W'(2);
    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_UNPRIMED = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GUESS_CHK,
        ST_LAST_CHK,
        ST_SCAN
    } state_t;

endpackage

>>> rtl/core/box_containing_point_finder_core.sv
// ----------------------------------------------------------------------------
// box_containing_point_finder_core
// Per-level tables of axis-aligned boxes with start, append and point query.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising edge with start high and busy low. Its one
//   result appears on found, box_index, status, last_valid and last_box for
//   exactly one cycle, marked by done; the receiver cannot stall, so every
//   result transfer completes in that cycle.
//   Start, append, unused codes and commands to an unprimed level finish in
//   the accept cycle: done follows in the next cycle and busy never rises.
//   A query reads boxes from one box memory through one shared containment
//   comparator, one read per cycle: the guessed box, then the last found
//   box, each only if valid and below the level's count, then a scan over
//   the level's n boxes. A query keeps busy high until a box is found or
//   the scan ends, and done follows its last cycle.
//   num_dims must be written through num_dims_we only while the core is idle;
//   the core does not enforce this. Reset clears the per-level counts, primed
//   flags and last-found flags and sets num_dims to three; the box memory
//   needs no clearing since only entries below a level's count are ever read.
// ----------------------------------------------------------------------------
module box_containing_point_finder_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   num_dims_we,
    input  logic [bcpf_pkg::DIMS_W-1:0]            num_dims,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [bcpf_pkg::CMD_W-1:0]             cmd,
    input  logic [bcpf_pkg::LEVEL_W-1:0]           level,
    input  logic signed [bcpf_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [bcpf_pkg::COORD_WIDTH-1:0] coord_y,
    input  logic signed [bcpf_pkg::COORD_WIDTH-1:0] coord_z,
    input  logic signed [bcpf_pkg::COORD_WIDTH-1:0] hi_x,
    input  logic signed [bcpf_pkg::COORD_WIDTH-1:0] hi_y,
    input  logic signed [bcpf_pkg::COORD_WIDTH-1:0] hi_z,
    input  logic                                   guess_valid,
    input  logic [bcpf_pkg::IDX_W-1:0]             guess_box,
    output logic                                   done,
    output logic                                   found,
    output logic [bcpf_pkg::IDX_W-1:0]             box_index,
    output logic [bcpf_pkg::STATUS_W-1:0]          status,
    output logic                                   last_valid,
    output logic [bcpf_pkg::IDX_W-1:0]             last_box
);
    import bcpf_pkg::*;

    localparam int CW = COORD_WIDTH;

    // configuration
    logic [DIMS_W-1:0] num_dims_reg;

    // per-level tables
    logic [CNT_W-1:0] box_count_reg [NUM_LEVELS];
    logic             primed_reg    [NUM_LEVELS];
    logic             lf_valid_reg  [NUM_LEVELS];
    logic [BOX_W-1:0] lf_box_reg    [NUM_LEVELS];

    // box memory: low corner in the lower half, high corner in the upper half
    logic [ENTRY_W-1:0] box_mem [NUM_LEVELS * MAX_BOXES];
    logic [ENTRY_W-1:0] rdata_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [LVL_W-1:0] lev_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [BOX_W-1:0] gbox_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             chk_reg, chk_next;
    logic signed [CW-1:0] px_reg, py_reg, pz_reg;

    // result registers
    logic             done_reg;
    logic             found_reg;
    logic [IDX_W-1:0] box_index_reg;
    status_t          status_reg;
    logic             last_valid_reg;
    logic [IDX_W-1:0] last_box_reg;

    // control strobes
    logic              accept;
    logic [LVL_W-1:0]  in_lev;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              clr_level;
    logic              inc_count;
    logic              set_last;
    logic              fin;
    logic              fin_found;
    logic [BOX_W-1:0]  fin_idx;
    status_t           fin_status;
    logic [LVL_W-1:0]  out_lev;
    logic              last_ok_in;
    logic              last_ok_cur;
    logic              guess_ok_in;
    logic [BOX_W-1:0]  chk_idx;

    // shared containment comparator
    logic in_x, in_y, in_z;
    logic hit3, hit_scan;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign in_lev = LVL_W'(level);

    always_comb
    begin
        in_x = (px_reg >= $signed(rdata_reg[0*CW +: CW]))
            && (px_reg <= $signed(rdata_reg[3*CW +: CW]));
        in_y = (py_reg >= $signed(rdata_reg[1*CW +: CW]))
            && (py_reg <= $signed(rdata_reg[4*CW +: CW]));
        in_z = (pz_reg >= $signed(rdata_reg[2*CW +: CW]))
            && (pz_reg <= $signed(rdata_reg[5*CW +: CW]));
        hit3     = in_x && in_y && in_z;
        hit_scan = in_x && in_y && (in_z || (num_dims_reg == DIMS_TWO));
    end

    // stale checks of the guess and of the last found box
    assign guess_ok_in = guess_valid && (CNT_W'(guess_box) < box_count_reg[in_lev]);
    assign last_ok_in  = lf_valid_reg[in_lev]
                      && (CNT_W'(lf_box_reg[in_lev]) < box_count_reg[in_lev]);
    assign last_ok_cur = lf_valid_reg[lev_reg] && (CNT_W'(lf_box_reg[lev_reg]) < cnt_reg);
    assign chk_idx     = BOX_W'(ptr_reg - CNT_W'(1));

    // sequencer next state and strobes
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        chk_next   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        clr_level  = 1'b0;
        inc_count  = 1'b0;
        set_last   = 1'b0;
        fin        = 1'b0;
        fin_found  = 1'b0;
        fin_idx    = '0;
        fin_status = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_START:
                        begin
                            clr_level = 1'b1;
                            fin       = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            fin = 1'b1;
                            if (!primed_reg[in_lev])
                                fin_status = STAT_UNPRIMED;
                            else if (box_count_reg[in_lev] >= CNT_W'(MAX_BOXES))
                                fin_status = STAT_FULL;
                            else
                            begin
                                wr_en     = 1'b1;
                                inc_count = 1'b1;
                                fin_idx   = BOX_W'(box_count_reg[in_lev]);
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!primed_reg[in_lev])
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_UNPRIMED;
                            end
                            else if (guess_ok_in)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = {in_lev, BOX_W'(guess_box)};
                                state_next = ST_GUESS_CHK;
                            end
                            else if (last_ok_in)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = {in_lev, lf_box_reg[in_lev]};
                                state_next = ST_LAST_CHK;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_GUESS_CHK:
            begin
                if (hit3)
                begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_idx    = gbox_reg;
                    set_last   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (last_ok_cur)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {lev_reg, lf_box_reg[lev_reg]};
                    state_next = ST_LAST_CHK;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_LAST_CHK:
            begin
                if (hit3)
                begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_idx    = lf_box_reg[lev_reg];
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read box ptr while checking the box read in the previous cycle
                if (chk_reg && hit_scan)
                begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_idx    = chk_idx;
                    set_last   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (ptr_reg < cnt_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = {lev_reg, BOX_W'(ptr_reg)};
                    chk_next = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chk_reg   <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            ptr_reg   <= ptr_next;
        end
    end

    // command operands captured at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lev_reg  <= in_lev;
            cnt_reg  <= box_count_reg[in_lev];
            gbox_reg <= BOX_W'(guess_box);
            px_reg   <= coord_x;
            py_reg   <= coord_y;
            pz_reg   <= coord_z;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_dims_reg <= DIMS_RESET;
        else if (num_dims_we)
            num_dims_reg <= num_dims;
    end

    // per-level counts and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                box_count_reg[i] <= '0;
                primed_reg[i]    <= 1'b0;
                lf_valid_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (clr_level)
            begin
                box_count_reg[in_lev] <= '0;
                primed_reg[in_lev]    <= 1'b1;
            end
            if (inc_count)
                box_count_reg[in_lev] <= box_count_reg[in_lev] + CNT_W'(1);
            if (set_last)
                lf_valid_reg[lev_reg] <= 1'b1;
        end
    end

    // last found box numbers
    always_ff @(posedge clk)
    begin
        if (set_last)
            lf_box_reg[lev_reg] <= fin_idx;
    end

    // box memory, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            box_mem[{in_lev, BOX_W'(box_count_reg[in_lev])}] <=
                {hi_z, hi_y, hi_x, coord_z, coord_y, coord_x};
        if (rd_en)
            rdata_reg <= box_mem[rd_addr];
    end

    // result registers
    assign out_lev = busy ? lev_reg : in_lev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin;
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            found_reg     <= fin_found;
            box_index_reg <= IDX_W'(fin_idx);
            status_reg    <= fin_status;
            if (set_last)
            begin
                last_valid_reg <= 1'b1;
                last_box_reg   <= IDX_W'(fin_idx);
            end
            else
            begin
                last_valid_reg <= lf_valid_reg[out_lev];
                last_box_reg   <= lf_valid_reg[out_lev] ? IDX_W'(lf_box_reg[out_lev]) : '0;
            end
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign box_index  = box_index_reg;
    assign status     = status_reg;
    assign last_valid = last_valid_reg;
    assign last_box   = last_box_reg;

`ifndef ASSERT_OFF
    // a result only follows an accepted command or a running query
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept || busy))
        else $error("result without a command");

    // a hit is only reported with ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == STAT_OK))
        else $error("hit reported with error status");

    // every hit leaves a valid last found box
    a_found_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> last_valid)
        else $error("hit without last found box");

    // scan pointer never passes the captured box count
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_reg <= cnt_reg))
        else $error("scan pointer beyond box count");
`endif

endmodule
